// ===== rtl/core/timed_serial_frame_writer_core_macros.svh =====
// Assertion helpers for the serial frame writer.
// Each macro expects clk and rst_n in scope and is disabled while in reset.
`ifndef TIMED_SERIAL_FRAME_WRITER_CORE_MACROS_SVH
`define TIMED_SERIAL_FRAME_WRITER_CORE_MACROS_SVH

// Same-cycle implication.
`define TSFW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tsfw_pkg.sv =====
package tsfw_pkg;

  // Frame length and derived widths.
  localparam int FRAME_BITS = 17;
  localparam int BITS_W     = $clog2(FRAME_BITS + 1);
  localparam int DLY_W      = 8;
  localparam int WAIT_W     = DLY_W + 1;
  localparam logic [DLY_W-1:0] DLY_RESET = 8'd5;

  // Sequencer phase codes.
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_START_HI  = 3'd1;
  localparam logic [2:0] PH_START_LO  = 3'd2;
  localparam logic [2:0] PH_SETUP     = 3'd3;
  localparam logic [2:0] PH_HIGH      = 3'd4;
  localparam logic [2:0] PH_LOW       = 3'd5;
  localparam logic [2:0] PH_STOP_WAIT = 3'd6;
  localparam logic [2:0] PH_STOP_HIGH = 3'd7;

  // Input item action codes.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Result word as it sits in the output register.
  typedef struct packed {
    logic busy;
    logic sda;
    logic scl;
  } line_state_t;

endpackage

// ===== rtl/core/timed_serial_frame_writer_core.sv =====
// Serial frame writer core: one input word yields one result word.
// A result appears in the output register in the cycle after its word is accepted.
// One word per cycle unless out_tready stalls; the output register refills as it drains.
// Reset (synchronous, rst_n low): idle, both lines high, delay register back to 5,
// output register empty.
`include "timed_serial_frame_writer_core_macros.svh"

module timed_serial_frame_writer_core (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration: delay register T.
  input  logic                      cfg_we,
  input  logic [tsfw_pkg::DLY_W-1:0] cfg_wdata,
  // Input channel.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [15:0]               in_tdata,   // [7:0] addr, [15:8] data
  input  logic                      in_tuser,   // [0] action
  // Result channel.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // [0] scl, [1] sda, [2] busy_res, zero pad
  output logic                      out_tlast   // done_res
);
  import tsfw_pkg::*;

  logic [DLY_W-1:0]      delay_r;
  logic [2:0]            phase_r, phase_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [BITS_W-1:0]     bits_left_r, bits_left_nxt;
  logic [WAIT_W-1:0]     wait_r, wait_nxt;
  logic                  scl_r, scl_nxt;
  logic                  sda_r, sda_nxt;
  logic                  done_nxt;
  logic                  out_valid_r;
  line_state_t           out_line_r;
  logic                  out_done_r;
  logic                  in_accept;
  logic [DLY_W-1:0]      dly_eff;
  logic [WAIT_W-1:0]     dly_one;
  logic [WAIT_W-1:0]     dly_two;
  logic [31:0]           frame_wide;
  logic [7:0]            in_addr;
  logic [7:0]            in_data;

  assign in_addr = in_tdata[7:0];
  assign in_data = in_tdata[15:8];

  // The output register frees up when empty or when its word is taken.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // A zero delay behaves as one tick.
  assign dly_eff = (delay_r == '0) ? {{(DLY_W-1){1'b0}}, 1'b1} : delay_r;
  assign dly_one = {1'b0, dly_eff};
  assign dly_two = {dly_eff, 1'b0};

  // Frame layout: address bits from bit 11 up, data byte from bit 1 up, cut to frame length.
  assign frame_wide = {13'd0, in_addr[6:0], 12'd0} >> 1 | {23'd0, in_data, 1'b0};

  // Next state of the line sequencer for the word on the input.
  always_comb begin
    phase_nxt     = phase_r;
    frame_nxt     = frame_r;
    bits_left_nxt = bits_left_r;
    wait_nxt      = wait_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    done_nxt      = 1'b0;
    if (in_tuser == ACT_START) begin
      if (phase_r == PH_IDLE) begin
        frame_nxt     = frame_wide[FRAME_BITS-1:0];
        bits_left_nxt = BITS_W'(FRAME_BITS);
        scl_nxt       = 1'b1;
        sda_nxt       = 1'b1;
        phase_nxt     = PH_START_HI;
        wait_nxt      = dly_one;
      end
    end else if (phase_r != PH_IDLE) begin
      if (wait_r > WAIT_W'(1)) begin
        wait_nxt = wait_r - WAIT_W'(1);
      end else begin
        unique case (phase_r)
          PH_START_HI: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_START_LO;
            wait_nxt  = dly_one;
          end
          PH_START_LO: begin
            sda_nxt   = frame_r[FRAME_BITS-1];
            frame_nxt = {frame_r[FRAME_BITS-2:0], 1'b0};
            phase_nxt = PH_SETUP;
            wait_nxt  = dly_one;
          end
          PH_SETUP: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_HIGH;
            wait_nxt  = dly_two;
          end
          PH_HIGH: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_LOW;
            wait_nxt  = dly_one;
          end
          PH_LOW: begin
            if (bits_left_r > BITS_W'(1)) begin
              bits_left_nxt = bits_left_r - BITS_W'(1);
              sda_nxt       = frame_r[FRAME_BITS-1];
              frame_nxt     = {frame_r[FRAME_BITS-2:0], 1'b0};
              phase_nxt     = PH_SETUP;
            end else begin
              bits_left_nxt = '0;
              phase_nxt     = PH_STOP_WAIT;
            end
            wait_nxt = dly_one;
          end
          PH_STOP_WAIT: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_STOP_HIGH;
            wait_nxt  = dly_one;
          end
          default: begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_IDLE;
            wait_nxt  = '0;
            done_nxt  = 1'b1;
          end
        endcase
      end
    end
  end

  // Delay register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DLY_RESET;
    end else if (cfg_we) begin
      delay_r <= cfg_wdata;
    end
  end

  // Sequencer state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      frame_r     <= '0;
      bits_left_r <= '0;
      wait_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
    end else if (in_accept) begin
      phase_r     <= phase_nxt;
      frame_r     <= frame_nxt;
      bits_left_r <= bits_left_nxt;
      wait_r      <= wait_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_line_r.scl  <= scl_nxt;
      out_line_r.sda  <= sda_nxt;
      out_line_r.busy <= (phase_nxt != PH_IDLE);
      out_done_r      <= done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_line_r.busy, out_line_r.sda, out_line_r.scl};
  assign out_tlast  = out_done_r;

  // Checks on the sequencer and the output register.
  `TSFW_ASSERT_NOW(a_done_not_busy, out_valid_r && out_done_r, !out_line_r.busy, "done while busy")
  `TSFW_ASSERT_NOW(a_idle_no_wait, phase_r == PH_IDLE, wait_r == '0, "idle with pending wait")
  `TSFW_ASSERT_NOW(a_busy_wait_set, phase_r != PH_IDLE, wait_r != '0, "busy with empty wait")
  `TSFW_ASSERT_NEXT(a_accept_fills, in_accept, out_valid_r, "accepted word produced no result")

endmodule
